### sv/irpdd_pkg.sv
// ----------------------------------------------------------------------------
// irpdd_pkg
// Shared types and constants for the IR pulse-distance decoder: interval
// windows, header phase codes and message store sizing.
// ----------------------------------------------------------------------------
package irpdd_pkg;

    localparam int TIME_W    = 32;
    localparam int CNT_W     = 6;
    localparam int STORE_W   = 32;
    localparam int IDX_W     = $clog2(STORE_W);
    localparam int PHASE_W   = 2;

    // Number of data bits in one message
    localparam int MSG_BITS    = 32;
    localparam int STORE_LIMIT = (MSG_BITS < STORE_W) ? MSG_BITS : STORE_W;
    localparam int COUNT_LIMIT = (MSG_BITS < 63) ? MSG_BITS : 63;

    // Open interval windows in microseconds
    localparam logic [TIME_W-1:0] HDR_MARK_LO  = 32'd8500;
    localparam logic [TIME_W-1:0] HDR_MARK_HI  = 32'd9500;
    localparam logic [TIME_W-1:0] HDR_SPACE_LO = 32'd4400;
    localparam logic [TIME_W-1:0] HDR_SPACE_HI = 32'd4600;
    localparam logic [TIME_W-1:0] BIT_MARK_LO  = 32'd400;
    localparam logic [TIME_W-1:0] BIT_MARK_HI  = 32'd750;
    localparam logic [TIME_W-1:0] ONE_LO       = 32'd900;
    localparam logic [TIME_W-1:0] ONE_HI       = 32'd1100;
    localparam logic [TIME_W-1:0] ZERO_LO      = 32'd1900;
    localparam logic [TIME_W-1:0] ZERO_HI      = 32'd2100;

    // Header phase codes
    localparam logic [PHASE_W-1:0] PHASE_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_MARK = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_FULL = 2'd2;

    typedef enum logic [2:0] {
        WIN_HDR_MARK,
        WIN_HDR_SPACE,
        WIN_BIT_MARK,
        WIN_ONE,
        WIN_ZERO,
        WIN_OTHER
    } window_t;

endpackage

### sv/irpdd_classify.sv
// ----------------------------------------------------------------------------
// irpdd_classify
// Sorts one edge-to-edge interval into its timing window.
// ----------------------------------------------------------------------------
module irpdd_classify (
    input  logic [irpdd_pkg::TIME_W-1:0] interval,
    output irpdd_pkg::window_t           window
);
    import irpdd_pkg::*;

    function automatic logic in_win(input logic [TIME_W-1:0] d,
                                    input logic [TIME_W-1:0] lo,
                                    input logic [TIME_W-1:0] hi);
        return (d > lo) && (d < hi);
    endfunction

    always_comb begin
        if (in_win(interval, HDR_MARK_LO, HDR_MARK_HI)) begin
            window = WIN_HDR_MARK;
        end else if (in_win(interval, HDR_SPACE_LO, HDR_SPACE_HI)) begin
            window = WIN_HDR_SPACE;
        end else if (in_win(interval, BIT_MARK_LO, BIT_MARK_HI)) begin
            window = WIN_BIT_MARK;
        end else if (in_win(interval, ONE_LO, ONE_HI)) begin
            window = WIN_ONE;
        end else if (in_win(interval, ZERO_LO, ZERO_HI)) begin
            window = WIN_ZERO;
        end else begin
            window = WIN_OTHER;
        end
    end

endmodule

### sv/irpdd_decode.sv
// ----------------------------------------------------------------------------
// irpdd_decode
// Protocol state and result registers: header phase, bit-mark flag, bit
// count, message store and sticky indicator, updated once per transfer.
// ----------------------------------------------------------------------------
module irpdd_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  irpdd_pkg::window_t            window,
    output logic                          bit_written,
    output logic                          bit_value,
    output logic [irpdd_pkg::CNT_W-1:0]   bit_count,
    output logic [irpdd_pkg::STORE_W-1:0] message_bits,
    output logic [irpdd_pkg::PHASE_W-1:0] header_phase,
    output logic                          indicator
);
    import irpdd_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               mark_reg, mark_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [STORE_W-1:0] msg_reg, msg_next;
    logic               ind_reg, ind_next;
    logic               written_reg, written_next;
    logic               value_reg, value_next;
    logic               store_en;
    logic               store_val;

    always_comb begin
        phase_next   = PHASE_IDLE;
        mark_next    = 1'b0;
        cnt_next     = cnt_reg;
        msg_next     = msg_reg;
        written_next = 1'b0;
        value_next   = 1'b0;
        store_en     = 1'b0;
        store_val    = 1'b0;

        unique case (window)
            WIN_HDR_MARK: begin
                phase_next = PHASE_MARK;
                cnt_next   = '0;
            end
            WIN_HDR_SPACE: begin
                phase_next = (phase_reg == PHASE_MARK) ? PHASE_FULL : PHASE_IDLE;
                cnt_next   = '0;
            end
            WIN_BIT_MARK: begin
                if (((phase_reg == PHASE_FULL) || (cnt_reg != '0)) && !mark_reg) begin
                    mark_next = 1'b1;
                end else begin
                    cnt_next = '0;
                end
            end
            WIN_ONE: begin
                if (mark_reg) begin
                    store_en  = 1'b1;
                    store_val = 1'b1;
                end else begin
                    cnt_next = '0;
                end
            end
            WIN_ZERO: begin
                store_en = mark_reg;
            end
            default: begin
                cnt_next = '0;
            end
        endcase

        // Store at the current count first, then advance the count
        if (store_en) begin
            if (cnt_reg < CNT_W'(STORE_LIMIT)) begin
                msg_next[cnt_reg[IDX_W-1:0]] = store_val;
                written_next                 = 1'b1;
                value_next                   = store_val;
            end
            if (cnt_reg < CNT_W'(COUNT_LIMIT)) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end

        ind_next = ind_reg | (cnt_next == CNT_W'(3));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PHASE_IDLE;
            mark_reg    <= 1'b0;
            cnt_reg     <= '0;
            msg_reg     <= '0;
            ind_reg     <= 1'b0;
            written_reg <= 1'b0;
            value_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            mark_reg    <= mark_next;
            cnt_reg     <= cnt_next;
            msg_reg     <= msg_next;
            ind_reg     <= ind_next;
            written_reg <= written_next;
            value_reg   <= value_next;
        end
    end

    assign bit_written  = written_reg;
    assign bit_value    = value_reg;
    assign bit_count    = cnt_reg;
    assign message_bits = msg_reg;
    assign header_phase = phase_reg;
    assign indicator    = ind_reg;

endmodule

### sv/ir_pulse_distance_decoder_top.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_top
// Decodes pulse-distance IR remote frames from edge capture timestamps.
// ----------------------------------------------------------------------------
// Path: an input transfer is registered in the input register, then in the
//   result register on the m_ channel. Throughput: 1 capture per cycle while
//   m_ready keeps up; the two-stage pipeline advances whenever the result is free.
// Reset: aresetn low clears both valid flags, the previous capture time and
//   all decoder state (idle header, zero count, empty message, indicator off).
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Edge capture input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [irpdd_pkg::TIME_W-1:0]  s_capture_time,
    // Decoded result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_bit_written,
    output logic                          m_bit_value,
    output logic [irpdd_pkg::CNT_W-1:0]   m_bit_count,
    output logic [irpdd_pkg::STORE_W-1:0] m_message_bits,
    output logic [irpdd_pkg::PHASE_W-1:0] m_header_phase,
    output logic                          m_indicator
);
    import irpdd_pkg::*;

    // Stage 1: interval register. The interval only needs the previous
    // capture, so form it at input transfer time and hold the capture.
    logic              in_valid_reg;
    logic [TIME_W-1:0] interval_reg;
    logic [TIME_W-1:0] last_capture_reg;
    logic              out_valid_reg;
    logic              s_fire;
    logic              advance;
    window_t           window;

    // Advance stage 1 into the result register when the result slot is free
    // or is being taken this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            last_capture_reg <= '0;
        end else begin
            if (s_fire) begin
                in_valid_reg     <= 1'b1;
                last_capture_reg <= s_capture_time;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Interval is modulo 2^32, so a timer wrap between captures is harmless
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            interval_reg <= s_capture_time - last_capture_reg;
        end
    end

    // Stage 2: classify the interval and update the decoder state
    irpdd_classify u_classify (
        .interval (interval_reg),
        .window   (window)
    );

    // Decoder state doubles as the result register: it only moves on
    // advance, so it holds steady while a result waits for m_ready.
    irpdd_decode u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .window       (window),
        .bit_written  (m_bit_written),
        .bit_value    (m_bit_value),
        .bit_count    (m_bit_count),
        .message_bits (m_message_bits),
        .header_phase (m_header_phase),
        .indicator    (m_indicator)
    );

    assign m_valid = out_valid_reg;

endmodule

### sv/irpdd_checker.sv
// ----------------------------------------------------------------------------
// irpdd_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module irpdd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_bit_written,
    input logic                          m_bit_value,
    input logic [irpdd_pkg::CNT_W-1:0]   m_bit_count,
    input logic [irpdd_pkg::STORE_W-1:0] m_message_bits,
    input logic [irpdd_pkg::PHASE_W-1:0] m_header_phase,
    input logic                          m_indicator
);
    import irpdd_pkg::*;

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_message_bits)
            && $stable(m_bit_count) && $stable(m_bit_written))
        else $error("stalled result changed");

    // A bit value of one only comes with a stored bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bit_value |-> m_bit_written)
        else $error("bit value without stored bit");

    // A stored bit always advances the count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bit_written |-> m_bit_count != '0)
        else $error("bit stored with zero count");

    // Header phases zero the count and never reach the unused code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_header_phase != PHASE_IDLE |-> m_bit_count == '0
            && (m_header_phase == PHASE_MARK || m_header_phase == PHASE_FULL))
        else $error("bad header phase");

    // Indicator is sticky until reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_indicator |=> m_indicator)
        else $error("indicator dropped");

endmodule

bind ir_pulse_distance_decoder_top irpdd_checker u_irpdd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_bit_written  (m_bit_written),
    .m_bit_value    (m_bit_value),
    .m_bit_count    (m_bit_count),
    .m_message_bits (m_message_bits),
    .m_header_phase (m_header_phase),
    .m_indicator    (m_indicator)
);

### verif/ir_pulse_distance_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_top_tb
// Drives edge capture timestamps into the IR pulse-distance decoder and
// checks every decoded result against an in-bench model of the header, bit
// mark and bit-space tracking. Directed cases cover timer wrap, window edges
// and stray symbols. Random framed traffic follows, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irpdd_pkg::*;

    localparam int RANDOM_CAPTURES = 1600;

    // One decoded result, laid out like the m_ channel payload.
    typedef struct packed {
        logic               bit_written;
        logic               bit_value;
        logic [CNT_W-1:0]   bit_count;
        logic [STORE_W-1:0] message_bits;
        logic [PHASE_W-1:0] header_phase;
        logic               indicator;
    } decode_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [TIME_W-1:0]   s_capture_time;
    logic                m_valid;
    logic                m_ready;
    logic                m_bit_written;
    logic                m_bit_value;
    logic [CNT_W-1:0]    m_bit_count;
    logic [STORE_W-1:0]  m_message_bits;
    logic [PHASE_W-1:0]  m_header_phase;
    logic                m_indicator;

    // Decoder model state, updated once per accepted capture.
    logic [TIME_W-1:0]   prev_capture;
    logic [PHASE_W-1:0]  hdr_phase;
    logic                mark_pending;
    logic [CNT_W-1:0]    bit_cnt;
    logic [STORE_W-1:0]  msg_word;
    logic                ind_flag;

    decode_result_t      pending_decodes[$];
    decode_result_t      seen_decode;
    decode_result_t      want_decode;
    int                  decode_errors;
    int                  captures_sent;
    int                  idle_max;
    logic [TIME_W-1:0]   edge_time;

    ir_pulse_distance_decoder_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_capture_time (s_capture_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bit_written  (m_bit_written),
        .m_bit_value    (m_bit_value),
        .m_bit_count    (m_bit_count),
        .m_message_bits (m_message_bits),
        .m_header_phase (m_header_phase),
        .m_indicator    (m_indicator)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Interval windows
    // ------------------------------------------------------------------------

    // Return the open bounds of one timing window.
    function automatic void window_limits(input window_t w, output logic [TIME_W-1:0] lo,
                                          output logic [TIME_W-1:0] hi);
        case (w)
            WIN_HDR_MARK: begin
                lo = HDR_MARK_LO;
                hi = HDR_MARK_HI;
            end
            WIN_HDR_SPACE: begin
                lo = HDR_SPACE_LO;
                hi = HDR_SPACE_HI;
            end
            WIN_BIT_MARK: begin
                lo = BIT_MARK_LO;
                hi = BIT_MARK_HI;
            end
            WIN_ONE: begin
                lo = ONE_LO;
                hi = ONE_HI;
            end
            WIN_ZERO: begin
                lo = ZERO_LO;
                hi = ZERO_HI;
            end
            default: begin
                lo = '0;
                hi = '0;
            end
        endcase
    endfunction

    // Windows are open: an interval equal to a bound is no symbol at all.
    function automatic window_t classify_interval(input logic [TIME_W-1:0] delta);
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        window_t           w;
        for (int k = 0; k < int'(WIN_OTHER); k++) begin
            w = window_t'(k);
            window_limits(w, lo, hi);
            if (delta > lo && delta < hi) return w;
        end
        return WIN_OTHER;
    endfunction

    // Draw an interval that lands in the given window; favor the edges a bit.
    function automatic logic [TIME_W-1:0] pick_interval(input window_t w);
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        logic [TIME_W-1:0] delta;
        if (w == WIN_OTHER) begin
            do begin
                case ($urandom_range(2, 0))
                    0: begin
                        window_limits(window_t'($urandom_range(int'(WIN_ZERO), 0)), lo, hi);
                        delta = $urandom_range(1, 0) ? hi : lo;
                    end
                    1:       delta = $urandom_range(12000, 0);
                    default: delta = $urandom();
                endcase
            end while (classify_interval(delta) != WIN_OTHER);
        end else begin
            window_limits(w, lo, hi);
            case ($urandom_range(7, 0))
                0:       delta = lo + 1;
                1:       delta = hi - 1;
                default: delta = $urandom_range(hi - 1, lo + 1);
            endcase
        end
        return delta;
    endfunction

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------

    // Store one data bit at the current count; drop it once the store is full.
    function automatic logic store_data_bit(input logic value);
        logic stored;
        stored = 1'b0;
        if (bit_cnt < STORE_LIMIT) begin
            msg_word[bit_cnt[IDX_W-1:0]] = value;
            stored = 1'b1;
        end
        // Saturate the count at the message length.
        if (bit_cnt < COUNT_LIMIT) bit_cnt = bit_cnt + 1'b1;
        return stored;
    endfunction

    function automatic decode_result_t decode_capture(input logic [TIME_W-1:0] stamp);
        decode_result_t r;
        logic [TIME_W-1:0] delta;
        r     = '0;
        delta = stamp - prev_capture;   // modulo 2^32, so timer wrap is harmless
        case (classify_interval(delta))
            WIN_HDR_MARK: begin
                hdr_phase    = PHASE_MARK;
                bit_cnt      = '0;
                mark_pending = 1'b0;
            end
            WIN_HDR_SPACE: begin
                hdr_phase    = (hdr_phase == PHASE_MARK) ? PHASE_FULL : PHASE_IDLE;
                mark_pending = 1'b0;
                bit_cnt      = '0;
            end
            WIN_BIT_MARK: begin
                // Arm only after a full header or inside a running message;
                // a second mark in a row aborts the message.
                if ((hdr_phase == PHASE_FULL || bit_cnt != '0) && !mark_pending) begin
                    mark_pending = 1'b1;
                end else begin
                    mark_pending = 1'b0;
                    bit_cnt      = '0;
                end
                hdr_phase = PHASE_IDLE;
            end
            WIN_ONE: begin
                if (mark_pending) begin
                    r.bit_written = store_data_bit(1'b1);
                    r.bit_value   = r.bit_written;
                end else begin
                    bit_cnt = '0;
                end
                mark_pending = 1'b0;
                hdr_phase    = PHASE_IDLE;
            end
            WIN_ZERO: begin
                // A stray zero-space keeps the count.
                if (mark_pending) r.bit_written = store_data_bit(1'b0);
                mark_pending = 1'b0;
                hdr_phase    = PHASE_IDLE;
            end
            default: begin
                mark_pending = 1'b0;
                bit_cnt      = '0;
                hdr_phase    = PHASE_IDLE;
            end
        endcase
        prev_capture = stamp;
        if (bit_cnt == 3) ind_flag = 1'b1;
        r.bit_count    = bit_cnt;
        r.message_bits = msg_word;
        r.header_phase = hdr_phase;
        r.indicator    = ind_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Capture driver
    // ------------------------------------------------------------------------

    // Present one capture at a falling edge, hold it until the transfer, then
    // record what the decoder must answer. Returns at the next falling edge.
    task automatic send_capture(input logic [TIME_W-1:0] stamp);
        int gap;
        gap = $urandom_range(idle_max, 0);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_capture_time <= stamp;
        do @(posedge aclk); while (!s_ready);
        pending_decodes.push_back(decode_capture(stamp));
        captures_sent++;
        @(negedge aclk);
    endtask

    // Advance the bench timer by one interval and capture it.
    task automatic send_interval(input logic [TIME_W-1:0] delta);
        edge_time = edge_time + delta;
        send_capture(edge_time);
    endtask

    // Send one symbol; in a broken frame, swap some symbols for random ones.
    task automatic send_symbol(input window_t w, input bit broken);
        window_t sym;
        sym = w;
        if (broken && $urandom_range(7, 0) == 0)
            sym = window_t'($urandom_range(int'(WIN_OTHER), 0));
        send_interval(pick_interval(sym));
    endtask

    // Header plus a run of data bits; some runs overflow the message store.
    task automatic send_frame(input bit broken);
        int nbits;
        nbits = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 30) : $urandom_range(34, 0);
        send_symbol(WIN_HDR_MARK, broken);
        send_symbol(WIN_HDR_SPACE, broken);
        repeat (nbits) begin
            send_symbol(WIN_BIT_MARK, broken);
            send_symbol($urandom_range(1, 0) ? WIN_ONE : WIN_ZERO, broken);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Capture at zero and at all ones, then a header that straddles the wrap.
    task automatic test_timer_wrap();
        edge_time = '0;
        send_interval(32'd0);
        send_interval(32'hFFFF_FFFF);
        send_interval(32'd9000);
        send_interval(32'd4500);
    endtask

    // Three bits to set the indicator, then double marks and stray spaces.
    task automatic test_bit_decoding();
        send_interval(32'd560);
        send_interval(32'd1000);
        send_interval(32'd560);
        send_interval(32'd2000);
        send_interval(32'd560);
        send_interval(32'd1000);
        send_interval(32'd560);
        send_interval(32'd560);
        send_interval(32'd2000);
        send_interval(32'd560);
        send_interval(32'd1000);
        send_interval(32'd4500);
    endtask

    // Every window bound exactly: each must fall through to no symbol.
    task automatic test_window_edges();
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        for (int k = 0; k < int'(WIN_OTHER); k++) begin
            window_limits(window_t'(k), lo, hi);
            send_interval(lo);
            send_interval(hi);
        end
    endtask

    // Mostly clean frames, some broken ones and bursts of noise; switch
    // between idling and back-to-back stretches per block.
    task automatic test_random_traffic();
        int start;
        start = captures_sent;
        while (captures_sent - start < RANDOM_CAPTURES) begin
            idle_max = ($urandom_range(4, 0) == 0) ? 0 : 3;
            case ($urandom_range(9, 0))
                7:       send_frame(1'b1);
                8, 9: begin
                    repeat ($urandom_range(5, 1))
                        send_symbol(window_t'($urandom_range(int'(WIN_OTHER), 0)), 1'b0);
                end
                default: send_frame(1'b0);
            endcase
        end
        idle_max = 3;
    endtask

    // ------------------------------------------------------------------------
    // Result sink: stall a random number of cycles before each transfer
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = $urandom_range(idle_max, 0);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // Result check: compare each transfer with the oldest pending decode
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_decode.bit_written  = m_bit_written;
            seen_decode.bit_value    = m_bit_value;
            seen_decode.bit_count    = m_bit_count;
            seen_decode.message_bits = m_message_bits;
            seen_decode.header_phase = m_header_phase;
            seen_decode.indicator    = m_indicator;
            if (pending_decodes.size() == 0) begin
                decode_errors++;
                if (decode_errors <= 10)
                    $display("%0t: unexpected result wr=%b val=%b cnt=%0d msg=%h ph=%0d ind=%b",
                             $realtime, m_bit_written, m_bit_value, m_bit_count,
                             m_message_bits, m_header_phase, m_indicator);
            end else begin
                want_decode = pending_decodes.pop_front();
                if (seen_decode.bit_written  !== want_decode.bit_written  ||
                    seen_decode.bit_value    !== want_decode.bit_value    ||
                    seen_decode.bit_count    !== want_decode.bit_count    ||
                    seen_decode.message_bits !== want_decode.message_bits ||
                    seen_decode.header_phase !== want_decode.header_phase ||
                    seen_decode.indicator    !== want_decode.indicator) begin
                    decode_errors++;
                    if (decode_errors <= 10) begin
                        $write("%0t: decode differs: wr %b/%b val %b/%b cnt %0d/%0d ",
                               $realtime,
                               want_decode.bit_written, seen_decode.bit_written,
                               want_decode.bit_value, seen_decode.bit_value,
                               want_decode.bit_count, seen_decode.bit_count);
                        $display("msg %h/%h ph %0d/%0d ind %b/%b (expected/actual)",
                                 want_decode.message_bits, seen_decode.message_bits,
                                 want_decode.header_phase, seen_decode.header_phase,
                                 want_decode.indicator, seen_decode.indicator);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int drain;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_capture_time = '0;
        decode_errors  = 0;
        captures_sent  = 0;
        idle_max       = 3;
        edge_time      = '0;

        // Model state matches the block right after reset.
        prev_capture = '0;
        hdr_phase    = PHASE_IDLE;
        mark_pending = 1'b0;
        bit_cnt      = '0;
        msg_word     = '0;
        ind_flag     = 1'b0;

        // Hold reset, then release it away from the rising edge.
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_timer_wrap();
        test_bit_decoding();
        test_window_edges();
        test_random_traffic();

        // Drop valid and drain the pipeline, then allow the block's latency.
        s_valid <= 1'b0;
        drain = 0;
        while (pending_decodes.size() != 0 && drain < 2000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (8) @(posedge aclk);

        if (pending_decodes.size() != 0) begin
            $display("%0d decoded results never arrived", pending_decodes.size());
            decode_errors += pending_decodes.size();
        end
        if (decode_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
